// ===== rtl/fca_pkg.sv =====
package fca_pkg;

  localparam int unsigned TABLE_SIZE = 4096;
  localparam int unsigned AW         = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W      = AW + 1;
  localparam int unsigned DW         = 16;
  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned STAT_W     = 3;

  // Longest chain that free or walk will follow before it reports a loop.
  localparam int unsigned DEPTH      = 4096;
  localparam int unsigned STEP_W     = $clog2(DEPTH + 1);

  localparam logic [DW-1:0] END_MARK = {DW{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START  = 3'd0,
    FUNC_EXTEND = 3'd1,
    FUNC_FREE   = 3'd2,
    FUNC_WALK   = 3'd3,
    FUNC_WRITE  = 3'd4,
    FUNC_READ   = 3'd5
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 3'd0,
    STAT_NOFREE = 3'd1,
    STAT_SHORT  = 3'd2,
    STAT_RANGE  = 3'd3,
    STAT_LOOP   = 3'd4
  } status_e;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } ram_req_t;

  // A data block lies in 1 .. count-1.
  function automatic logic is_data_block(logic [DW-1:0] idx, logic [CNT_W-1:0] cnt);
    logic [DW-1:0] cnt_ext;
    cnt_ext = DW'(cnt);
    return (idx != '0) && (idx < cnt_ext);
  endfunction

endpackage

// ===== rtl/fca_req_if.sv =====
interface fca_req_if import fca_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [DW-1:0]     block_index;
  logic [DW-1:0]     hop_count;
  logic [DW-1:0]     entry_value;

  modport source (output valid, func, block_index, hop_count, entry_value, input ready);
  modport sink   (input valid, func, block_index, hop_count, entry_value, output ready);
endinterface

// ===== rtl/fca_rsp_if.sv =====
interface fca_rsp_if import fca_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DW-1:0]     result_index;
  logic [STAT_W-1:0] status;

  modport source (output valid, result_index, status, input ready);
  modport sink   (input valid, result_index, status, output ready);
endinterface

// ===== rtl/fca_cfg_if.sv =====
interface fca_cfg_if import fca_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data_block_count;

  modport source (output valid, data_block_count, input ready);
  modport sink   (input valid, data_block_count, output ready);
endinterface

// ===== rtl/fca_table.sv =====
module fca_table import fca_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ram_req_t      req_i,
  output logic [DW-1:0] rdata_o,
  output logic          busy_o
);

  logic [DW-1:0] mem [TABLE_SIZE];
  logic [AW-1:0] clr_q;
  logic          busy_q;
  logic [DW-1:0] rdata_q;

  // After reset every entry is swept to zero, one per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      clr_q <= clr_q + AW'(1);
      if (clr_q == {AW{1'b1}}) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= '0;
    end else if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

// ===== rtl/fat_chain_allocator.sv =====
// Channel  Direction  Payload                                         Accepted when
// req_i    in         func, block_index, hop_count, entry_value      valid && ready
// rsp_o    out        result_index, status                           valid && ready
// cfg_i    in         data_block_count                               valid && ready
//
// Each word on req_i gives exactly one word on rsp_o; the block takes no new word on req_i
// until the result of the last one has gone to the output register. After reset the table
// is swept to zero, during which req_i is not ready; cfg_i is always ready. A finished
// result waits in the output register while the next word is taken, and the block stalls
// only when a second result is ready before the first is read.
module fat_chain_allocator import fca_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fca_req_if.sink   req_i,
  fca_rsp_if.source rsp_o,
  fca_cfg_if.sink   cfg_i
);

  // One-hot sequencer. Every table read is issued in one cycle and its data decided on in the
  // next, so a write always lands before the next read of the same entry is issued.
  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_EXT_CHK  = 10'b00_0000_0010,
    S_SRCH     = 10'b00_0000_0100,
    S_EXT_LINK = 10'b00_0000_1000,
    S_FREE_RD  = 10'b00_0001_0000,
    S_FREE_WB  = 10'b00_0010_0000,
    S_WALK_CHK = 10'b00_0100_0000,
    S_WALK_NXT = 10'b00_1000_0000,
    S_READ     = 10'b01_0000_0000,
    S_RESP     = 10'b10_0000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cfg_q;
  logic [CNT_W-1:0]  cnt;
  logic [FUNC_W-1:0] func_q, func_d;
  logic [DW-1:0]     idx_q, idx_d;
  logic [DW-1:0]     hops_q, hops_d;
  logic [AW-1:0]     cur_q, cur_d;
  logic [STEP_W-1:0] steps_q, steps_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     pidx_q, pidx_d;
  logic [DW-1:0]     res_q, res_d;
  status_e           stat_q, stat_d;
  logic              out_valid_q, out_valid_d;
  logic [DW-1:0]     out_res_q, out_res_d;
  logic [STAT_W-1:0] out_stat_q, out_stat_d;

  ram_req_t          ram_req;
  logic [DW-1:0]     rdata;
  logic              clr_busy;
  logic              req_acc;
  logic              scan_issue;

  fca_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram_req),
    .rdata_o (rdata),
    .busy_o  (clr_busy)
  );

  // A count above the table size behaves as the table size.
  assign cnt = (cfg_q > CNT_W'(TABLE_SIZE)) ? CNT_W'(TABLE_SIZE) : cfg_q;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == S_IDLE) && !clr_busy;
  assign req_acc     = req_i.valid && req_i.ready;
  assign scan_issue  = scan_q < cnt;

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    idx_d       = idx_q;
    hops_d      = hops_q;
    cur_d       = cur_q;
    steps_d     = steps_q;
    scan_d      = scan_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    res_d       = res_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_res_d   = out_res_q;
    out_stat_d  = out_stat_q;
    ram_req     = '0;

    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          func_d  = req_i.func;
          idx_d   = req_i.block_index;
          hops_d  = req_i.hop_count;
          cur_d   = req_i.block_index[AW-1:0];
          steps_d = '0;
          scan_d  = CNT_W'(1);
          pend_d  = 1'b0;
          res_d   = '0;
          stat_d  = STAT_OK;
          state_d = S_RESP;
          case (req_i.func)
            FUNC_START: begin
              state_d = S_SRCH;
            end
            FUNC_EXTEND: begin
              if (is_data_block(req_i.block_index, cnt)) begin
                ram_req.re    = 1'b1;
                ram_req.raddr = req_i.block_index[AW-1:0];
                state_d       = S_EXT_CHK;
              end else begin
                stat_d = STAT_RANGE;
              end
            end
            FUNC_FREE: begin
              // The empty chain frees nothing and succeeds.
              if (req_i.block_index == END_MARK) begin
                stat_d = STAT_OK;
              end else if (is_data_block(req_i.block_index, cnt)) begin
                state_d = S_FREE_RD;
              end else begin
                stat_d = STAT_RANGE;
              end
            end
            FUNC_WALK: begin
              if (req_i.block_index == END_MARK) begin
                stat_d = STAT_SHORT;
              end else if (is_data_block(req_i.block_index, cnt)) begin
                state_d = S_WALK_CHK;
              end else begin
                stat_d = STAT_RANGE;
              end
            end
            FUNC_WRITE: begin
              if (req_i.block_index < DW'(cnt)) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = req_i.block_index[AW-1:0];
                ram_req.wdata = req_i.entry_value;
              end else begin
                stat_d = STAT_RANGE;
              end
            end
            FUNC_READ: begin
              if (req_i.block_index < DW'(cnt)) begin
                ram_req.re    = 1'b1;
                ram_req.raddr = req_i.block_index[AW-1:0];
                state_d       = S_READ;
              end else begin
                stat_d = STAT_RANGE;
              end
            end
            default: begin
              stat_d = STAT_RANGE;
            end
          endcase
        end
      end

      S_EXT_CHK: begin
        // Only the tail of a chain may be extended.
        if (rdata != END_MARK) begin
          stat_d  = STAT_RANGE;
          state_d = S_RESP;
        end else begin
          state_d = S_SRCH;
        end
      end

      S_SRCH: begin
        // First-fit scan: one read issued per cycle, its data checked in the next one.
        ram_req.re    = scan_issue;
        ram_req.raddr = scan_q[AW-1:0];
        pend_d        = scan_issue;
        pidx_d        = scan_q[AW-1:0];
        if (scan_issue) begin
          scan_d = scan_q + CNT_W'(1);
        end
        if (pend_q && (rdata == '0)) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pidx_q;
          ram_req.wdata = END_MARK;
          res_d         = DW'(pidx_q);
          state_d       = (func_q == FUNC_EXTEND) ? S_EXT_LINK : S_RESP;
        end else if (!scan_issue && !pend_q) begin
          stat_d  = STAT_NOFREE;
          state_d = S_RESP;
        end
      end

      S_EXT_LINK: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_q[AW-1:0];
        ram_req.wdata = res_q;
        state_d       = S_RESP;
      end

      S_FREE_RD: begin
        if (steps_q >= STEP_W'(DEPTH)) begin
          stat_d  = STAT_LOOP;
          state_d = S_RESP;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = cur_q;
          state_d       = S_FREE_WB;
        end
      end

      S_FREE_WB: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cur_q;
        ram_req.wdata = '0;
        steps_d       = steps_q + STEP_W'(1);
        if (rdata == END_MARK) begin
          state_d = S_RESP;
        end else if (!is_data_block(rdata, cnt)) begin
          stat_d  = STAT_RANGE;
          state_d = S_RESP;
        end else begin
          cur_d   = rdata[AW-1:0];
          state_d = S_FREE_RD;
        end
      end

      S_WALK_CHK: begin
        if (32'(steps_q) >= 32'(hops_q)) begin
          res_d   = DW'(cur_q);
          state_d = S_RESP;
        end else if (steps_q >= STEP_W'(DEPTH)) begin
          stat_d  = STAT_LOOP;
          state_d = S_RESP;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = cur_q;
          state_d       = S_WALK_NXT;
        end
      end

      S_WALK_NXT: begin
        if (rdata == END_MARK) begin
          stat_d  = STAT_SHORT;
          state_d = S_RESP;
        end else if (!is_data_block(rdata, cnt)) begin
          stat_d  = STAT_RANGE;
          state_d = S_RESP;
        end else begin
          cur_d   = rdata[AW-1:0];
          steps_d = steps_q + STEP_W'(1);
          state_d = S_WALK_CHK;
        end
      end

      S_READ: begin
        res_d   = rdata;
        state_d = S_RESP;
      end

      S_RESP: begin
        // Hand the result over once the output register is free or being emptied.
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_stat_d  = stat_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= CNT_W'(TABLE_SIZE);
      out_valid_q <= 1'b0;
      steps_q     <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      steps_q     <= steps_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      if (cfg_i.valid) begin
        cfg_q <= cfg_i.data_block_count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    idx_q      <= idx_d;
    hops_q     <= hops_d;
    cur_q      <= cur_d;
    pidx_q     <= pidx_d;
    res_q      <= res_d;
    stat_q     <= stat_d;
    out_res_q  <= out_res_d;
    out_stat_q <= out_stat_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_index = out_res_q;
  assign rsp_o.status       = out_stat_q;

`ifndef SYNTHESIS
  // No request may be taken while the table is still being cleared.
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !req_i.ready)
    else $error("request accepted during table clear");

  // A block found by the search is always a data block of the current count.
  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SRCH) && pend_q && (rdata == '0)) |->
      ((pidx_q != '0) && (CNT_W'(pidx_q) < cnt)))
    else $error("search returned a block outside the data range");

  // The step counter of free and walk never passes the cap.
  a_step_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= STEP_W'(DEPTH))
    else $error("step counter beyond cap");

  // A result waiting in the output register is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready && (state_q == S_RESP)) |=> (state_q == S_RESP))
    else $error("pending result overwritten");
`endif

endmodule

// ===== dv/fca_table_checker.sv =====
module fca_table_checker import fca_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_ready_i,
  input  logic [FUNC_W-1:0] req_func_i,
  input  logic [DW-1:0]     req_block_index_i,
  input  logic [DW-1:0]     req_hop_count_i,
  input  logic [DW-1:0]     req_entry_value_i,
  input  logic              rsp_valid_i,
  input  logic              rsp_ready_i,
  input  logic [DW-1:0]     rsp_result_index_i,
  input  logic [STAT_W-1:0] rsp_status_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [CNT_W-1:0]  cfg_count_i,
  output int unsigned       pending_o,
  output int unsigned       fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DW-1:0] result_index;
    status_e       status;
  } table_answer_t;

  // Mirror of the allocation table and of the block count register.
  logic [DW-1:0]    fat_mirror [TABLE_SIZE];
  logic [CNT_W-1:0] count_mirror;
  table_answer_t    answers_due [$];

  // Register values above the table size behave as the table size.
  function automatic int unsigned live_count();
    return (count_mirror > TABLE_SIZE) ? TABLE_SIZE : int'(count_mirror);
  endfunction

  function automatic bit is_live_block(input logic [DW-1:0] idx);
    return (idx != '0) && (idx < live_count());
  endfunction

  // First-fit search over the data blocks; 0 means nothing is free.
  function automatic int unsigned first_free_block();
    for (int unsigned i = 1; i < live_count(); i++) begin
      if (fat_mirror[i] == '0) return i;
    end
    return 0;
  endfunction

  task automatic run_request(input  logic [FUNC_W-1:0] func,
                             input  logic [DW-1:0]     idx,
                             input  logic [DW-1:0]     hops,
                             input  logic [DW-1:0]     val,
                             output logic [DW-1:0]     res,
                             output status_e           st);
    int unsigned   slot;
    int unsigned   steps;
    logic [DW-1:0] cur;
    logic [DW-1:0] nxt;
    res = '0;
    st  = STAT_OK;
    case (func)
      FUNC_START: begin
        slot = first_free_block();
        if (slot == 0) begin
          st = STAT_NOFREE;
        end else begin
          fat_mirror[slot] = END_MARK;
          res = DW'(slot);
        end
      end
      FUNC_EXTEND: begin
        if (!is_live_block(idx) || fat_mirror[idx[AW-1:0]] != END_MARK) begin
          st = STAT_RANGE;
        end else begin
          slot = first_free_block();
          if (slot == 0) begin
            st = STAT_NOFREE;
          end else begin
            fat_mirror[idx[AW-1:0]] = DW'(slot);
            fat_mirror[slot] = END_MARK;
            res = DW'(slot);
          end
        end
      end
      FUNC_FREE: begin
        // A head of END_MARK is the empty chain and needs no work.
        if (idx != END_MARK) begin
          if (!is_live_block(idx)) begin
            st = STAT_RANGE;
          end else begin
            cur   = idx;
            steps = 0;
            forever begin
              if (steps >= DEPTH) begin
                st = STAT_LOOP;
                break;
              end
              nxt = fat_mirror[cur[AW-1:0]];
              fat_mirror[cur[AW-1:0]] = '0;
              steps++;
              if (nxt == END_MARK) break;
              if (!is_live_block(nxt)) begin
                st = STAT_RANGE;
                break;
              end
              cur = nxt;
            end
          end
        end
      end
      FUNC_WALK: begin
        if (idx == END_MARK) begin
          st = STAT_SHORT;
        end else if (!is_live_block(idx)) begin
          st = STAT_RANGE;
        end else begin
          cur = idx;
          for (steps = 0; steps < hops; steps++) begin
            if (steps >= DEPTH) begin
              st = STAT_LOOP;
              break;
            end
            nxt = fat_mirror[cur[AW-1:0]];
            if (nxt == END_MARK) begin
              st = STAT_SHORT;
              break;
            end
            if (!is_live_block(nxt)) begin
              st = STAT_RANGE;
              break;
            end
            cur = nxt;
          end
          if (st == STAT_OK) res = cur;
        end
      end
      FUNC_WRITE: begin
        if (idx < live_count()) fat_mirror[idx[AW-1:0]] = val;
        else st = STAT_RANGE;
      end
      FUNC_READ: begin
        if (idx < live_count()) res = fat_mirror[idx[AW-1:0]];
        else st = STAT_RANGE;
      end
      default: st = STAT_RANGE;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    table_answer_t due;
    logic [DW-1:0] got_index;
    status_e       got_status;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SIZE; i++) fat_mirror[i] = '0;
      count_mirror = CNT_W'(TABLE_SIZE);
      answers_due.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      // A result word always belongs to an older request, so it is matched first.
      if (rsp_valid_i && rsp_ready_i) begin
        if (answers_due.size() == 0) begin
          $error("result word with nothing outstanding: result_index %0d status %0d",
                 rsp_result_index_i, rsp_status_i);
          fail_count_o++;
        end else begin
          due = answers_due.pop_front();
          if (rsp_result_index_i !== due.result_index) begin
            $error("result_index: expected %0d, got %0d", due.result_index,
                   rsp_result_index_i);
            fail_count_o++;
          end
          if (rsp_status_i !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, rsp_status_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) count_mirror = cfg_count_i;
      if (req_valid_i && req_ready_i) begin
        run_request(req_func_i, req_block_index_i, req_hop_count_i, req_entry_value_i,
                    got_index, got_status);
        due.result_index = got_index;
        due.status       = got_status;
        answers_due.push_back(due);
      end
      pending_o = answers_due.size();
    end
  end

endmodule

// ===== dv/fat_chain_allocator_test.sv =====
module fat_chain_allocator_test import fca_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned MAX_GAP      = 9;
  localparam int unsigned ITEM_BUDGET  = 800;
  // The slowest legal item walks DEPTH links; the limit allows for every item being that slow
  // with both sides idling as long as they may, three times over, plus the table sweep that
  // follows reset.
  localparam longint unsigned CYCLE_LIMIT =
    longint'(3) * ITEM_BUDGET * (2 * DEPTH + 4 + 2 * MAX_GAP) + 2 * TABLE_SIZE;
  // Once nothing is outstanding, wait out the longest item before the verdict so that a
  // stray result word would still be caught.
  localparam int unsigned SETTLE_CYCLES = 2 * DEPTH + 16;

  // Function codes the block does not define; both must be rejected.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  fca_req_if req_if ();
  fca_rsp_if rsp_if ();
  fca_cfg_if cfg_if ();

  int unsigned     words_pending;
  int unsigned     fail_total;
  longint unsigned cycle_count = 0;

  // Stimulus bookkeeping: the count last written, the functions of accepted request words
  // still awaiting their result, and a pool of blocks recently handed out by start and
  // extend, so that chain operations mostly work on real chains.
  int unsigned       count_now = TABLE_SIZE;
  logic [FUNC_W-1:0] inflight_funcs [$];
  logic [DW-1:0]     known_blocks [$];
  bit                tx_quiet = 1'b0;
  bit                rx_quiet = 1'b0;

  fat_chain_allocator u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  fca_table_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .req_valid_i        (req_if.valid),
    .req_ready_i        (req_if.ready),
    .req_func_i         (req_if.func),
    .req_block_index_i  (req_if.block_index),
    .req_hop_count_i    (req_if.hop_count),
    .req_entry_value_i  (req_if.entry_value),
    .rsp_valid_i        (rsp_if.valid),
    .rsp_ready_i        (rsp_if.ready),
    .rsp_result_index_i (rsp_if.result_index),
    .rsp_status_i       (rsp_if.status),
    .cfg_valid_i        (cfg_if.valid),
    .cfg_ready_i        (cfg_if.ready),
    .cfg_count_i        (cfg_if.data_block_count),
    .pending_o          (words_pending),
    .fail_count_o       (fail_total)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: a hung handshake or a lost result word ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fat_chain_allocator_test: errors");
      $finish;
    end
  end

  function automatic int unsigned live_count();
    return (count_now > TABLE_SIZE) ? TABLE_SIZE : count_now;
  endfunction

  // An entry index around the working range: mostly 0 .. count, which takes in entry 0 and
  // the first index past the end, now and then any 16-bit value.
  function automatic logic [DW-1:0] entry_pick();
    if ($urandom_range(0, 7) == 0) return DW'($urandom());
    return DW'($urandom_range(0, live_count()));
  endfunction

  // A chain head or tail. With newest set the most recently granted block is favoured, which
  // is nearly always the tail of the chain that is being grown.
  function automatic logic [DW-1:0] chain_pick(input bit newest);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (known_blocks.size() != 0 && r < 7) begin
      if (newest && r < 4) return known_blocks[$];
      return known_blocks[$urandom_range(0, known_blocks.size() - 1)];
    end
    if (r < 9) return entry_pick();
    return ($urandom_range(0, 1) != 0) ? END_MARK : DW'($urandom());
  endfunction

  // Present one request word after a random gap and hold it until it is taken. The valid
  // line is only lowered when a gap is drawn, so a back-to-back word never sees valid
  // dropped and raised in the same step.
  task automatic send_word(input logic [FUNC_W-1:0] func,
                           input logic [DW-1:0]     idx,
                           input logic [DW-1:0]     hops,
                           input logic [DW-1:0]     val);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.func        <= func;
    req_if.block_index <= idx;
    req_if.hop_count   <= hops;
    req_if.entry_value <= val;
    do @(posedge clk); while (!req_if.ready);
    inflight_funcs.push_back(func);
  endtask

  // Stop sending and wait until every request word has had its result.
  task automatic drain();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
  endtask

  // The count is only changed while the block is idle; every word gives exactly one result,
  // so an empty set of outstanding results means idle.
  task automatic set_block_count(input int unsigned n);
    drain();
    @(negedge clk);
    cfg_if.valid            <= 1'b1;
    cfg_if.data_block_count <= CNT_W'(n);
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    count_now = n;
  endtask

  // One random word. Most are start, extend, walk and free on chains that exist; the rest are
  // entry accesses that also break and knot chains, undefined codes and plain noise.
  task automatic send_random_word();
    int unsigned       pick;
    logic [FUNC_W-1:0] func;
    logic [DW-1:0]     idx;
    logic [DW-1:0]     hops;
    logic [DW-1:0]     val;
    pick = $urandom_range(0, 99);
    idx  = DW'($urandom());
    hops = DW'($urandom());
    val  = DW'($urandom());
    if (pick < 20) begin
      func = FUNC_START;
    end else if (pick < 40) begin
      func = FUNC_EXTEND;
      idx  = chain_pick(1'b1);
    end else if (pick < 55) begin
      func = FUNC_WALK;
      idx  = chain_pick(1'b0);
      if ($urandom_range(0, 15) != 0) hops = DW'($urandom_range(0, 6));
    end else if (pick < 65) begin
      func = FUNC_FREE;
      idx  = chain_pick(1'b0);
    end else if (pick < 80) begin
      func = FUNC_READ;
      idx  = entry_pick();
    end else if (pick < 92) begin
      func = FUNC_WRITE;
      idx  = entry_pick();
      case ($urandom_range(0, 7))
        0:       val = '0;
        1, 2:    val = END_MARK;
        7:       val = DW'($urandom());
        default: val = DW'($urandom_range(0, live_count()));
      endcase
    end else if (pick < 96) begin
      func = ($urandom_range(0, 1) != 0) ? FUNC_UNUSED_HI : FUNC_UNUSED_LO;
    end else begin
      func = FUNC_W'($urandom_range(0, 7));
    end
    send_word(func, idx, hops, val);
  endtask

  // Result side: a random stall before each word, with quiet stretches in which ready stays
  // high. Grants from start and extend are noted for later chain operations.
  initial begin : result_sink
    int unsigned       stall;
    logic [FUNC_W-1:0] func;
    rsp_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      @(negedge clk);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      func = (inflight_funcs.size() != 0) ? inflight_funcs.pop_front() : FUNC_UNUSED_LO;
      if (rsp_if.status == STAT_OK && (func == FUNC_START || func == FUNC_EXTEND)) begin
        known_blocks.push_back(rsp_if.result_index);
        if (known_blocks.size() > 24) void'(known_blocks.pop_front());
      end
    end
  end

  initial begin : stimulus
    int unsigned setting;
    int unsigned words;
    req_if.valid            = 1'b0;
    req_if.func             = '0;
    req_if.block_index      = '0;
    req_if.hop_count        = '0;
    req_if.entry_value      = '0;
    cfg_if.valid            = 1'b0;
    cfg_if.data_block_count = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, at the full table size.
    set_block_count(TABLE_SIZE);
    send_word(FUNC_READ, END_MARK, '0, '0);          // far out of range
    send_word(FUNC_READ, DW'(TABLE_SIZE), '0, '0);   // first index past the table
    send_word(FUNC_READ, DW'(TABLE_SIZE - 1), '0, '0);
    send_word(FUNC_START, '0, '0, '0);               // first fit gives block 1
    send_word(FUNC_START, '0, '0, '0);
    send_word(FUNC_EXTEND, 16'd2, '0, '0);
    send_word(FUNC_EXTEND, 16'd1, '0, '0);
    send_word(FUNC_EXTEND, 16'd2, '0, '0);           // no longer a tail
    send_word(FUNC_EXTEND, 16'd0, '0, '0);           // entry 0 is no data block
    send_word(FUNC_WALK, 16'd1, 16'd0, '0);
    send_word(FUNC_WALK, 16'd2, 16'd1, '0);
    send_word(FUNC_WALK, 16'd2, 16'd2, '0);          // runs off the end of the chain
    send_word(FUNC_WALK, END_MARK, 16'd0, '0);       // empty chain, even with no hops
    send_word(FUNC_WRITE, 16'd0, '0, END_MARK);      // entry 0 may be written and read
    send_word(FUNC_READ, 16'd0, '0, '0);
    send_word(FUNC_WRITE, DW'(TABLE_SIZE), '0, 16'h1234);
    send_word(FUNC_WRITE, DW'(TABLE_SIZE - 1), '0, END_MARK);
    // Two entries pointing at each other: the walk hits the step cap, the free then finds a
    // cleared link on its way round.
    send_word(FUNC_WRITE, 16'd10, '0, 16'd11);
    send_word(FUNC_WRITE, 16'd11, '0, 16'd10);
    send_word(FUNC_WALK, 16'd10, END_MARK, '0);
    send_word(FUNC_FREE, 16'd10, '0, '0);
    // A link beyond the count breaks the walk; the free after it releases the chain at block 1.
    send_word(FUNC_WRITE, 16'd20, '0, DW'(TABLE_SIZE));
    send_word(FUNC_WALK, 16'd20, 16'd3, '0);
    send_word(FUNC_FREE, 16'd1, '0, '0);
    send_word(FUNC_FREE, END_MARK, '0, '0);          // freeing the empty chain is harmless
    send_word(FUNC_FREE, 16'd0, '0, '0);
    send_word(FUNC_UNUSED_LO, 16'd1, 16'd1, 16'd1);
    send_word(FUNC_UNUSED_HI, END_MARK, END_MARK, END_MARK);

    // Random part over a run of counts: small tables that fill up quickly, the smallest
    // legal count, counts that leave no data block at all, the largest register value and
    // a few random sizes.
    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       begin setting = 16;                          words = 100; end
        1:       begin setting = 2;                           words = 40;  end
        2:       begin setting = 0;                           words = 25;  end
        3:       begin setting = 1;                           words = 25;  end
        4:       begin setting = (1 << CNT_W) - 1;            words = 80;  end
        5:       begin setting = 64;                          words = 120; end
        6:       begin setting = $urandom_range(3, 40);       words = 100; end
        7:       begin setting = TABLE_SIZE;                  words = 90;  end
        8:       begin setting = $urandom_range(2, TABLE_SIZE); words = 60; end
        default: begin setting = TABLE_SIZE - 1;              words = 40;  end
      endcase
      set_block_count(setting);
      for (int unsigned n = 0; n < words; n++) begin
        if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
        // Now and then hold off until the block has answered everything.
        if ($urandom_range(0, 59) == 0) drain();
        send_random_word();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_total == 0) begin
      $display("fat_chain_allocator_test: clean");
    end else begin
      $display("fat_chain_allocator_test: errors");
    end
    $finish;
  end

endmodule
